// ===== rtl/ba_pkg.sv =====
// ----------------------------------------------------------------------------
// ba_pkg - shared types and constants for the buddy allocator
// Field widths, status and operation codes, sequencer states and the
// memory control group passed between the sequencer and the record store.
// ----------------------------------------------------------------------------
package ba_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int TOT_RESET     = 10;
  localparam int CFG_W         = 4;
  localparam int SIZE_W        = 11;
  localparam int ADDR_W        = 10;
  localparam int STAT_W        = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOROOM  = 2'd1,
    STAT_FREED   = 2'd2,
    STAT_BADADDR = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_A_SIZE,
    S_A_SRCH,
    S_A_SPLIT,
    S_RM_RD,
    S_RM_GET,
    S_RM_PRD,
    S_RM_PWR,
    S_RM_N,
    S_RM_NWR,
    S_RM_END,
    S_APP,
    S_AP_RD,
    S_AP_WR,
    S_F_RD,
    S_F_CHK,
    S_F_STEP,
    S_F_BUD
  } ba_st_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== rtl/ba_mem.sv =====
// ----------------------------------------------------------------------------
// ba_mem - per-address record store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ba_mem import ba_pkg::*; #(
  parameter int AW = MAX_ORDER_DEF,
  parameter int DW = 8
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] raddr,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ba_seq.sv =====
// ----------------------------------------------------------------------------
// ba_seq - allocator sequencer
// Walks orders, searches and splits free lists and merges buddies with
// at most one record access per step. Free lists are doubly linked
// through the store; list heads and tails per order sit in flops.
// ----------------------------------------------------------------------------
module ba_seq import ba_pkg::*; #(
  parameter  int MAX_ORDER = MAX_ORDER_DEF,
  localparam int AW = MAX_ORDER,
  localparam int OW = $clog2(MAX_ORDER + 2),
  localparam int DW = 2 * AW + 2 + 2 * OW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rebuild,
  input  logic [OW-1:0]     tot,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] blk_addr,
  output logic              res_valid,
  output logic [STAT_W-1:0] res_status,
  output logic [ADDR_W-1:0] res_addr,
  output logic [SIZE_W-1:0] res_size,
  output mem_ctl_t          mem_ctl,
  output logic [AW-1:0]     mem_raddr,
  output logic [AW-1:0]     mem_waddr,
  output logic [DW-1:0]     mem_wdata,
  input  logic [DW-1:0]     mem_rdata
);

  localparam int SW    = (MAX_ORDER + 1 > SIZE_W) ? MAX_ORDER + 1 : SIZE_W;
  localparam int DEPTH = MAX_ORDER + 1;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [AW-1:0] nxt;
    logic          nv;
    logic [AW-1:0] prv;
    logic          pv;
    logic [OW-1:0] ftag;
    logic [OW-1:0] aord;
  } rec_t;

  ba_st_t        st_r, st_nxt;
  logic [OW-1:0] k_r, k_nxt, o_r, o_nxt;
  logic [AW-1:0] a_r, a_nxt, x_r, x_nxt, p_r, p_nxt, n_r, n_nxt, apt_r, apt_nxt;
  logic          pv_r, pv_nxt, nv_r, nv_nxt;
  op_t           op_r, op_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] head_r [DEPTH];
  logic [AW-1:0] head_nxt [DEPTH];
  logic [AW-1:0] tail_r [DEPTH];
  logic [AW-1:0] tail_nxt [DEPTH];
  logic [DEPTH-1:0] hv_r, hv_nxt;
  logic          ov_r, ov_nxt;
  status_t       ost_r, ost_nxt;
  logic [AW-1:0] oaddr_r, oaddr_nxt;
  logic [SW-1:0] osize_r, osize_nxt;

  rec_t          rd, wrec;
  logic [IW-1:0] o_idx;
  logic [SW-1:0] region, pow_k, pow_o, pow_om1;
  logic [AW-1:0] bud_bit, half, bud;
  logic [OW-1:0] o_p1, o_m1, k_p1;
  logic          size_ok, in_range, ftag_hit;

  always_comb begin
    rd       = rec_t'(mem_rdata);
    o_idx    = o_r[IW-1:0];
    o_p1     = o_r + 1'b1;
    o_m1     = o_r - 1'b1;
    k_p1     = k_r + 1'b1;
    region   = SW'(1) << tot;
    pow_k    = SW'(1) << k_r;
    pow_o    = SW'(1) << o_r;
    pow_om1  = SW'(1) << o_m1;
    bud_bit  = pow_o[AW-1:0];
    half     = pow_om1[AW-1:0];
    bud      = a_r ^ bud_bit;
    size_ok  = (size_r != '0) && (size_r <= region);
    in_range = ((a_r >> tot) == '0);
    ftag_hit = (rd.ftag == o_p1);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:    if (start) st_nxt = (op == OP_FREE) ? S_F_RD : S_A_SIZE;
      S_CLEAR:   if (clr_r == '0) st_nxt = S_IDLE;
      S_A_SIZE: begin
        if (!size_ok)            st_nxt = S_IDLE;
        else if (pow_k >= size_r) st_nxt = S_A_SRCH;
      end
      S_A_SRCH: begin
        if (o_r > tot)        st_nxt = S_IDLE;
        else if (hv_r[o_idx]) st_nxt = S_RM_RD;
      end
      S_A_SPLIT: st_nxt = (o_r == k_r) ? S_IDLE : S_APP;
      S_RM_RD:   st_nxt = S_RM_GET;
      S_RM_GET:  st_nxt = rd.pv ? S_RM_PRD : S_RM_N;
      S_RM_PRD:  st_nxt = S_RM_PWR;
      S_RM_PWR:  st_nxt = S_RM_N;
      S_RM_N:    st_nxt = nv_r ? S_RM_NWR : S_RM_END;
      S_RM_NWR:  st_nxt = S_RM_END;
      S_RM_END:  st_nxt = (op_r == OP_ALLOC) ? S_A_SPLIT : S_F_STEP;
      S_APP: begin
        if (hv_r[o_idx])           st_nxt = S_AP_RD;
        else if (op_r == OP_ALLOC) st_nxt = S_A_SPLIT;
        else                       st_nxt = S_IDLE;
      end
      S_AP_RD:   st_nxt = S_AP_WR;
      S_AP_WR:   st_nxt = (op_r == OP_ALLOC) ? S_A_SPLIT : S_IDLE;
      S_F_RD:    st_nxt = in_range ? S_F_CHK : S_IDLE;
      S_F_CHK:   st_nxt = (rd.aord == '0) ? S_IDLE : S_F_STEP;
      S_F_STEP:  st_nxt = (o_r < tot) ? S_F_BUD : S_APP;
      S_F_BUD:   st_nxt = ftag_hit ? S_RM_RD : S_APP;
      default:   st_nxt = S_IDLE;
    endcase
    if (rebuild) st_nxt = S_CLEAR;
  end

  // datapath and store accesses
  always_comb begin
    k_nxt     = k_r;
    o_nxt     = o_r;
    a_nxt     = a_r;
    x_nxt     = x_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    pv_nxt    = pv_r;
    nv_nxt    = nv_r;
    apt_nxt   = apt_r;
    op_nxt    = op_r;
    size_nxt  = size_r;
    clr_nxt   = clr_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    hv_nxt    = hv_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    oaddr_nxt = oaddr_r;
    osize_nxt = osize_r;
    mem_ctl   = '0;
    mem_raddr = x_r;
    mem_waddr = x_r;
    wrec      = rd;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = op_t'(op);
          size_nxt = SW'(req_size);
          a_nxt    = AW'(blk_addr);
          k_nxt    = '0;
        end
      end
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = clr_r;
        wrec          = '0;
        clr_nxt       = clr_r - 1'b1;
        if (clr_r == '0) begin
          // last word: the whole region as one free block at address 0
          wrec.ftag            = tot + 1'b1;
          hv_nxt               = '0;
          hv_nxt[tot[IW-1:0]]  = 1'b1;
          head_nxt[tot[IW-1:0]] = '0;
          tail_nxt[tot[IW-1:0]] = '0;
        end
      end
      S_A_SIZE: begin
        if (!size_ok) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_NOROOM;
          oaddr_nxt = '0;
          osize_nxt = '0;
        end else if (pow_k < size_r) begin
          k_nxt = k_p1;
        end else begin
          o_nxt = k_r;
        end
      end
      S_A_SRCH: begin
        if (o_r > tot) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_NOROOM;
          oaddr_nxt = '0;
          osize_nxt = '0;
        end else if (hv_r[o_idx]) begin
          a_nxt = head_r[o_idx];
          x_nxt = head_r[o_idx];
        end else begin
          o_nxt = o_p1;
        end
      end
      S_A_SPLIT: begin
        if (o_r == k_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_OK;
          oaddr_nxt = a_r;
          osize_nxt = pow_k;
        end else begin
          o_nxt = o_m1;
          x_nxt = a_r + half;
        end
      end
      S_RM_RD: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = x_r;
      end
      S_RM_GET: begin
        p_nxt  = rd.prv;
        pv_nxt = rd.pv;
        n_nxt  = rd.nxt;
        nv_nxt = rd.nv;
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = x_r;
        wrec.ftag     = '0;
        if (op_r == OP_ALLOC) wrec.aord = k_p1;
        if (!rd.pv) begin
          head_nxt[o_idx] = rd.nxt;
          hv_nxt[o_idx]   = rd.nv;
        end
      end
      S_RM_PRD: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = p_r;
      end
      S_RM_PWR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = p_r;
        wrec.nxt      = n_r;
        wrec.nv       = nv_r;
      end
      S_RM_N: begin
        if (nv_r) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = n_r;
        end else begin
          tail_nxt[o_idx] = p_r;
        end
      end
      S_RM_NWR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = n_r;
        wrec.prv      = p_r;
        wrec.pv       = pv_r;
      end
      S_RM_END: begin
        if (op_r == OP_FREE) begin
          if (x_r < a_r) a_nxt = x_r;
          o_nxt = o_p1;
        end
      end
      S_APP: begin
        mem_ctl.wr_en   = 1'b1;
        mem_waddr       = x_r;
        wrec            = '0;
        wrec.prv        = tail_r[o_idx];
        wrec.pv         = hv_r[o_idx];
        wrec.ftag       = o_p1;
        apt_nxt         = tail_r[o_idx];
        if (!hv_r[o_idx]) head_nxt[o_idx] = x_r;
        tail_nxt[o_idx] = x_r;
        hv_nxt[o_idx]   = 1'b1;
        if (!hv_r[o_idx] && op_r == OP_FREE) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_FREED;
          oaddr_nxt = x_r;
          osize_nxt = pow_k;
        end
      end
      S_AP_RD: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = apt_r;
      end
      S_AP_WR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = apt_r;
        wrec.nxt      = x_r;
        wrec.nv       = 1'b1;
        if (op_r == OP_FREE) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_FREED;
          oaddr_nxt = x_r;
          osize_nxt = pow_k;
        end
      end
      S_F_RD: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = a_r;
        if (!in_range) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_BADADDR;
          oaddr_nxt = '0;
          osize_nxt = '0;
        end
      end
      S_F_CHK: begin
        if (rd.aord == '0) begin
          ov_nxt    = 1'b1;
          ost_nxt   = STAT_BADADDR;
          oaddr_nxt = '0;
          osize_nxt = '0;
        end else begin
          k_nxt         = rd.aord - 1'b1;
          o_nxt         = rd.aord - 1'b1;
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = a_r;
          wrec.aord     = '0;
        end
      end
      S_F_STEP: begin
        if (o_r < tot) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = bud;
        end else begin
          x_nxt = a_r;
        end
      end
      S_F_BUD: begin
        // buddy free at the same order: unlink it and merge
        x_nxt = ftag_hit ? bud : a_r;
      end
      default: ;
    endcase
  end

  assign mem_wdata = DW'(wrec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '1;
      hv_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= rebuild ? '1 : clr_nxt;
      hv_r  <= hv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    o_r      <= o_nxt;
    a_r      <= a_nxt;
    x_r      <= x_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    pv_r     <= pv_nxt;
    nv_r     <= nv_nxt;
    apt_r    <= apt_nxt;
    op_r     <= op_nxt;
    size_r   <= size_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    ost_r    <= ost_nxt;
    oaddr_r  <= oaddr_nxt;
    osize_r  <= osize_nxt;
  end

  assign busy       = (st_r != S_IDLE);
  assign res_valid  = ov_r;
  assign res_status = ost_r;
  assign res_addr   = ADDR_W'(oaddr_r);
  assign res_size   = SIZE_W'(osize_r);

  logic [SW-1:0] kmask;
  assign kmask = pow_k - 1'b1;

  a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("store read and write in the same cycle");

  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(st_r) != S_IDLE)
    else $error("result word without a request in flight");

  a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_A_SPLIT && o_r == k_r) |-> ((a_r & kmask[AW-1:0]) == '0))
    else $error("allocated block not aligned to its size");

endmodule

// ===== rtl/buddy_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_allocator - buddy allocator over a 2^total_order unit region
// Allocate rounds up to a power of two and splits the oldest block of the
// smallest fitting free list; free merges with free buddies.
//
//  channel  ports                              handshake
//  in       in_operation/request_size/addr     start & !busy
//  out      out_status/result_address/size     out_valid, one cycle, no stall
//  cfg      cfg_data (total_order)             cfg_valid & cfg_ready
//
// Allocate rounds the size up, searches orders upward, unlinks the head
// block and splits it down. Free checks the record, merges with each free
// buddy, then appends the result. Each step makes at most one store access.
// After reset and each cfg write a clearing pass over every store word runs
// with busy high. Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module buddy_allocator import ba_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_block_address,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_result_address,
  output logic [SIZE_W-1:0] out_result_size,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AW  = MAX_ORDER;
  localparam int OW  = $clog2(MAX_ORDER + 2);
  localparam int DW  = 2 * AW + 2 + 2 * OW;
  localparam int XW  = (OW > CFG_W) ? OW : CFG_W;
  localparam int TRS = (TOT_RESET > MAX_ORDER) ? MAX_ORDER : TOT_RESET;

  logic [OW-1:0] tot_r, tot_nxt;
  logic [XW-1:0] cfg_ext;
  logic          cfg_fire;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // oversized orders saturate
  always_comb begin
    cfg_ext = XW'(cfg_data);
    tot_nxt = tot_r;
    if (cfg_fire) begin
      if (cfg_ext > XW'(MAX_ORDER)) tot_nxt = OW'(MAX_ORDER);
      else                          tot_nxt = OW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= OW'(TRS);
    end else begin
      tot_r <= tot_nxt;
    end
  end

  ba_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .raddr (mem_raddr),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ba_seq #(.MAX_ORDER(MAX_ORDER)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .rebuild    (cfg_fire),
    .tot        (tot_r),
    .start      (start),
    .busy       (busy),
    .op         (in_operation),
    .req_size   (in_request_size),
    .blk_addr   (in_block_address),
    .res_valid  (out_valid),
    .res_status (out_status),
    .res_addr   (out_result_address),
    .res_size   (out_result_size),
    .mem_ctl    (mem_ctl),
    .mem_raddr  (mem_raddr),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

endmodule
